FILE: src/sgfix_pkg.sv
package sgfix_pkg;

    // quotient bits produced by each divider
    localparam int SGF_QW = 32;

    // configuration register indexes
    localparam int SGF_CFG_IW = 2;
    localparam logic [SGF_CFG_IW-1:0] CFG_MIN_DENSITY  = 2'd0;
    localparam logic [SGF_CFG_IW-1:0] CFG_MIN_GAMMA    = 2'd1;
    localparam logic [SGF_CFG_IW-1:0] CFG_MIN_PRESSURE = 2'd2;

    // signed 32-bit limits and 1.0 in Q15.16
    localparam logic signed [31:0] SGF_S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SGF_S32_MIN = 32'sh80000000;
    localparam logic signed [32:0] SGF_ONE     = 33'sd65536;

    // input word: one cell
    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
        logic signed [31:0] energy;
        logic signed [31:0] gamma_term;
        logic signed [31:0] pressure_term;
    } t_in;

    // output word
    typedef struct packed {
        logic signed [31:0] new_density;
        logic signed [31:0] new_energy;
        logic signed [31:0] new_gamma_term;
        logic signed [31:0] new_pressure_term;
    } t_out;

    // clamped quantities carried down the pipe
    typedef struct packed {
        logic signed [31:0] r_new;
        logic signed [31:0] g_new;
        logic signed [31:0] p_new;
    } t_clamp;

    // signed, saturated quotient from a magnitude quotient and flags
    function automatic logic signed [31:0] sgf_sat_quo(input logic neg, input logic ovf,
                                                       input logic zz, input logic [31:0] qm);
        logic signed [31:0] res;
        if (zz) begin
            res = '0;
        end else if (ovf) begin
            res = neg ? SGF_S32_MIN : SGF_S32_MAX;
        end else if (!neg) begin
            res = qm[31] ? SGF_S32_MAX : $signed(qm);
        end else if (qm > 32'h80000000) begin
            res = SGF_S32_MIN;
        end else begin
            res = $signed(~qm + 32'd1);
        end
        return res;
    endfunction

    // saturate a 52-bit signed value to 32 bits
    function automatic logic signed [31:0] sgf_sat52(input logic signed [51:0] v);
        logic signed [31:0] res;
        if (v > 52'sd2147483647) begin
            res = SGF_S32_MAX;
        end else if (v < -52'sd2147483648) begin
            res = SGF_S32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: src/stiffened_gas_state_fixup_core.sv
// throughput: one word per cycle while the skid word is empty
// 76 register stages, two 32-stage dividers in series
// a full output register and skid word hold the pipe, the input stays ready until then
// reset: synchronous, active low; clears valid bits and the three minimum registers
module stiffened_gas_state_fixup_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sgfix_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sgfix_pkg::t_out                     o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sgfix_pkg::SGF_CFG_IW-1:0]    i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);
    import sgfix_pkg::*;

    typedef struct packed {
        t_clamp             c;
        logic signed [31:0] e_old;
        logic signed [31:0] p_old;
        logic signed [31:0] g_old;
        logic               ovf;
        logic               zz;
        logic               neg;
    } t_kside;

    typedef struct packed {
        logic ovf;
        logic zz;
        logic neg;
    } t_qside;

    typedef struct packed {
        t_clamp             c;
        logic signed [31:0] ke;
        logic signed [31:0] q;
        logic               ovf;
        logic               zz;
        logic               neg;
    } t_pside;

    logic w_en;

    // configuration registers
    logic signed [31:0] r_min_d;
    logic signed [31:0] r_min_g;
    logic signed [31:0] r_min_p;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_d <= '0;
            r_min_g <= '0;
            r_min_p <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_DENSITY:  r_min_d <= $signed(i_cfg_data);
                CFG_MIN_GAMMA:    r_min_g <= $signed(i_cfg_data);
                CFG_MIN_PRESSURE: r_min_p <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_in_ready = w_en;

    // stage a: clamps and squares
    logic               r_a_v;
    t_clamp             r_a_c;
    logic signed [31:0] r_a_e;
    logic signed [31:0] r_a_pold;
    logic signed [31:0] r_a_gold;
    logic signed [31:0] r_a_rold;
    logic signed [63:0] r_a_sqx;
    logic signed [63:0] r_a_sqy;
    logic signed [63:0] r_a_sqz;

    // stage b: partial sum, density divisor, 1+G
    logic               r_b_v;
    t_clamp             r_b_c;
    logic signed [31:0] r_b_e;
    logic signed [31:0] r_b_pold;
    logic signed [31:0] r_b_gold;
    logic [63:0]        r_b_sxy;
    logic [63:0]        r_b_sqz;
    logic [32:0]        r_b_kden;
    logic               r_b_rneg;
    logic signed [32:0] r_b_d;

    // stage c: full sum, magnitudes for the q divide
    logic               r_c_v;
    t_clamp             r_c_c;
    logic signed [31:0] r_c_e;
    logic signed [31:0] r_c_pold;
    logic signed [31:0] r_c_gold;
    logic [63:0]        r_c_sum;
    logic [32:0]        r_c_kden;
    logic               r_c_rneg;
    logic [31:0]        r_c_dabs;
    logic [31:0]        r_c_pabs;
    logic               r_c_qneg;
    logic               r_c_qzz;

    // stage d: divider set-up
    logic               r_d_v;
    t_kside             r_d_ks;
    logic [32:0]        r_d_krem;
    logic [31:0]        r_d_klow;
    logic [32:0]        r_d_kden;
    t_qside             r_d_qs;
    logic [31:0]        r_d_qrem;
    logic [31:0]        r_d_qlow;
    logic [31:0]        r_d_qden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    logic [32:0] w_b_rext;
    logic [32:0] w_b_rabs;
    logic [31:0] w_d_khi;
    logic [31:0] w_d_qhi;
    logic        w_d_kovf;
    logic        w_d_qovf;

    assign w_b_rext = {r_a_rold[31], r_a_rold};
    assign w_b_rabs = r_a_rold[31] ? (33'd0 - w_b_rext) : w_b_rext;
    assign w_d_khi  = r_c_sum[63:32];
    assign w_d_kovf = {1'b0, w_d_khi} >= r_c_kden;
    assign w_d_qhi  = {16'd0, r_c_pabs[31:16]};
    assign w_d_qovf = w_d_qhi >= r_c_dabs;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage a
            r_a_c.r_new <= (i_in_data.density > r_min_d) ? i_in_data.density : r_min_d;
            r_a_c.g_new <= (i_in_data.gamma_term > r_min_g) ? i_in_data.gamma_term : r_min_g;
            r_a_c.p_new <= (i_in_data.pressure_term > r_min_p) ?
                           i_in_data.pressure_term : r_min_p;
            r_a_e    <= i_in_data.energy;
            r_a_pold <= i_in_data.pressure_term;
            r_a_gold <= i_in_data.gamma_term;
            r_a_rold <= i_in_data.density;
            r_a_sqx  <= i_in_data.mom_x * i_in_data.mom_x;
            r_a_sqy  <= i_in_data.mom_y * i_in_data.mom_y;
            r_a_sqz  <= i_in_data.mom_z * i_in_data.mom_z;
            // stage b
            r_b_c    <= r_a_c;
            r_b_e    <= r_a_e;
            r_b_pold <= r_a_pold;
            r_b_gold <= r_a_gold;
            r_b_sxy  <= $unsigned(r_a_sqx) + $unsigned(r_a_sqy);
            r_b_sqz  <= $unsigned(r_a_sqz);
            r_b_kden <= {w_b_rabs[31:0], 1'b0};
            r_b_rneg <= r_a_rold[31];
            r_b_d    <= $signed({r_a_c.g_new[31], r_a_c.g_new}) + SGF_ONE;
            // stage c
            r_c_c    <= r_b_c;
            r_c_e    <= r_b_e;
            r_c_pold <= r_b_pold;
            r_c_gold <= r_b_gold;
            r_c_sum  <= r_b_sxy + r_b_sqz;
            r_c_kden <= r_b_kden;
            r_c_rneg <= r_b_rneg;
            r_c_dabs <= r_b_d[32] ? (~r_b_d[31:0] + 32'd1) : r_b_d[31:0];
            r_c_pabs <= r_b_c.p_new[31] ? (~r_b_c.p_new + 32'd1) : r_b_c.p_new;
            r_c_qneg <= r_b_d[32] ^ r_b_c.p_new[31];
            r_c_qzz  <= (r_b_d == 33'sd0) && (r_b_c.p_new == 32'sd0);
            // stage d
            r_d_ks.c     <= r_c_c;
            r_d_ks.e_old <= r_c_e;
            r_d_ks.p_old <= r_c_pold;
            r_d_ks.g_old <= r_c_gold;
            r_d_ks.ovf   <= w_d_kovf;
            r_d_ks.zz    <= (r_c_kden == 33'd0) && (r_c_sum == 64'd0);
            r_d_ks.neg   <= r_c_rneg;
            r_d_krem     <= w_d_kovf ? 33'd0 : {1'b0, w_d_khi};
            r_d_klow     <= r_c_sum[31:0];
            r_d_kden     <= r_c_kden;
            r_d_qs.ovf   <= w_d_qovf;
            r_d_qs.zz    <= r_c_qzz;
            r_d_qs.neg   <= r_c_qneg;
            r_d_qrem     <= w_d_qovf ? 32'd0 : w_d_qhi;
            r_d_qlow     <= {r_c_pabs[15:0], 16'd0};
            r_d_qden     <= r_c_dabs;
        end
    end

    // kinetic energy and q dividers, side by side
    logic        w_kv;
    logic        w_qv;
    logic [31:0] w_kq;
    logic [31:0] w_qq;
    t_kside      w_ks;
    t_qside      w_qs;

    sgfix_div #(.DW(33), .PW($bits(t_kside))) u_ke_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_v),
        .i_rem   (r_d_krem),
        .i_low   (r_d_klow),
        .i_den   (r_d_kden),
        .i_side  (r_d_ks),
        .o_valid (w_kv),
        .o_quo   (w_kq),
        .o_side  (w_ks)
    );

    sgfix_div #(.DW(32), .PW($bits(t_qside))) u_q_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_v),
        .i_rem   (r_d_qrem),
        .i_low   (r_d_qlow),
        .i_den   (r_d_qden),
        .i_side  (r_d_qs),
        .o_valid (w_qv),
        .o_quo   (w_qq),
        .o_side  (w_qs)
    );

    // stage e: saturate ke and q
    logic               r_e_v;
    t_clamp             r_e_c;
    logic signed [31:0] r_e_e;
    logic signed [31:0] r_e_pold;
    logic signed [31:0] r_e_gold;
    logic signed [31:0] r_e_ke;
    logic signed [31:0] r_e_q;

    // stage f: pressure numerator
    logic               r_f_v;
    t_clamp             r_f_c;
    logic signed [31:0] r_f_gold;
    logic signed [31:0] r_f_ke;
    logic signed [31:0] r_f_q;
    logic signed [33:0] r_f_num;

    // stage g: pressure divider set-up
    logic               r_g_v;
    t_pside             r_g_ps;
    logic [31:0]        r_g_rem;
    logic [31:0]        r_g_low;
    logic [31:0]        r_g_den;

    logic [32:0] w_g_nabs;
    logic [31:0] w_g_gabs;
    logic [31:0] w_g_hi;
    logic        w_g_ovf;

    assign w_g_nabs = r_f_num[33] ? (~r_f_num[32:0] + 33'd1) : r_f_num[32:0];
    assign w_g_gabs = r_f_gold[31] ? (~r_f_gold + 32'd1) : r_f_gold;
    assign w_g_hi   = {15'd0, w_g_nabs[32:16]};
    assign w_g_ovf  = w_g_hi >= w_g_gabs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= w_kv && w_qv;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage e
            r_e_c    <= w_ks.c;
            r_e_e    <= w_ks.e_old;
            r_e_pold <= w_ks.p_old;
            r_e_gold <= w_ks.g_old;
            r_e_ke   <= sgf_sat_quo(w_ks.neg, w_ks.ovf, w_ks.zz, w_kq);
            r_e_q    <= sgf_sat_quo(w_qs.neg, w_qs.ovf, w_qs.zz, w_qq);
            // stage f
            r_f_c    <= r_e_c;
            r_f_gold <= r_e_gold;
            r_f_ke   <= r_e_ke;
            r_f_q    <= r_e_q;
            r_f_num  <= $signed({{2{r_e_e[31]}}, r_e_e}) - $signed({{2{r_e_pold[31]}}, r_e_pold})
                        - $signed({{2{r_e_ke[31]}}, r_e_ke});
            // stage g
            r_g_ps.c   <= r_f_c;
            r_g_ps.ke  <= r_f_ke;
            r_g_ps.q   <= r_f_q;
            r_g_ps.ovf <= w_g_ovf;
            r_g_ps.zz  <= (r_f_gold == 32'sd0) && (r_f_num == 34'sd0);
            r_g_ps.neg <= r_f_num[33] ^ r_f_gold[31];
            r_g_rem    <= w_g_ovf ? 32'd0 : w_g_hi;
            r_g_low    <= {w_g_nabs[15:0], 16'd0};
            r_g_den    <= w_g_gabs;
        end
    end

    // pressure divider
    logic        w_pv;
    logic [31:0] w_pq;
    t_pside      w_ps;

    sgfix_div #(.DW(32), .PW($bits(t_pside))) u_pres_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_v),
        .i_rem   (r_g_rem),
        .i_low   (r_g_low),
        .i_den   (r_g_den),
        .i_side  (r_g_ps),
        .o_valid (w_pv),
        .o_quo   (w_pq),
        .o_side  (w_ps)
    );

    // stage h: saturate pressure, form 1+G
    logic               r_h_v;
    t_clamp             r_h_c;
    logic signed [31:0] r_h_ke;
    logic signed [31:0] r_h_q;
    logic signed [31:0] r_h_pres;
    logic signed [32:0] r_h_d;

    // stage i: products and correction flag
    logic               r_i_v;
    t_clamp             r_i_c;
    logic signed [31:0] r_i_ke;
    logic signed [64:0] r_i_pd;
    logic signed [63:0] r_i_pg;
    logic               r_i_flag;

    // stage j: truncate products toward zero
    logic               r_j_v;
    t_clamp             r_j_c;
    logic signed [31:0] r_j_ke;
    logic signed [48:0] r_j_t1;
    logic signed [47:0] r_j_t2;
    logic               r_j_flag;

    // stage k: corrected pressure term
    logic               r_k_v;
    t_clamp             r_k_c;
    logic signed [31:0] r_k_ke;
    logic signed [47:0] r_k_t2;
    logic signed [31:0] r_k_pout;

    // stage l: new energy
    logic               r_l_v;
    t_out               r_l_o;

    logic signed [33:0] w_i_m2;
    logic signed [50:0] w_k_t1x;
    logic signed [50:0] w_k_m4;

    assign w_i_m2  = 34'sd0 - $signed({r_h_pres[31], r_h_pres, 1'b0});
    assign w_k_t1x = $signed({{2{r_j_t1[48]}}, r_j_t1});
    assign w_k_m4  = 51'sd0 - $signed({w_k_t1x[48:0], 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
            r_k_v <= 1'b0;
            r_l_v <= 1'b0;
        end else if (w_en) begin
            r_h_v <= w_pv;
            r_i_v <= r_h_v;
            r_j_v <= r_i_v;
            r_k_v <= r_j_v;
            r_l_v <= r_k_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage h
            r_h_c    <= w_ps.c;
            r_h_ke   <= w_ps.ke;
            r_h_q    <= w_ps.q;
            r_h_pres <= sgf_sat_quo(w_ps.neg, w_ps.ovf, w_ps.zz, w_pq);
            r_h_d    <= $signed({w_ps.c.g_new[31], w_ps.c.g_new}) + SGF_ONE;
            // stage i
            r_i_c    <= r_h_c;
            r_i_ke   <= r_h_ke;
            r_i_pd   <= r_h_pres * r_h_d;
            r_i_pg   <= r_h_pres * r_h_c.g_new;
            r_i_flag <= w_i_m2 > $signed({{2{r_h_q[31]}}, r_h_q});
            // stage j
            r_j_c    <= r_i_c;
            r_j_ke   <= r_i_ke;
            r_j_t1   <= r_i_pd[64:16] + {48'd0, (r_i_pd[64] && (r_i_pd[15:0] != 16'd0))};
            r_j_t2   <= r_i_pg[63:16] + {47'd0, (r_i_pg[63] && (r_i_pg[15:0] != 16'd0))};
            r_j_flag <= r_i_flag;
            // stage k
            r_k_c    <= r_j_c;
            r_k_ke   <= r_j_ke;
            r_k_t2   <= r_j_t2;
            r_k_pout <= r_j_flag ? sgf_sat52($signed({w_k_m4[50], w_k_m4})) : r_j_c.p_new;
            // stage l
            r_l_o.new_density       <= r_k_c.r_new;
            r_l_o.new_gamma_term    <= r_k_c.g_new;
            r_l_o.new_pressure_term <= r_k_pout;
            r_l_o.new_energy        <= sgf_sat52($signed({{4{r_k_t2[47]}}, r_k_t2})
                                        + $signed({{20{r_k_pout[31]}}, r_k_pout})
                                        + $signed({{20{r_k_ke[31]}}, r_k_ke}));
        end
    end

    // output register and skid word
    sgfix_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_l_v),
        .i_data      (r_l_o),
        .o_en        (w_en),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    // both first-pass dividers carry the same word
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_kv == w_qv)
        else $error("ke and q dividers out of step");

    // zero density divisor must take the overflow path
    a_ke_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_v && (r_d_kden == 33'd0)) |-> r_d_ks.ovf)
        else $error("zero density divisor not flagged");

    // zero G divisor must take the overflow path
    a_pres_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g_v && (r_g_den == 32'd0)) |-> r_g_ps.ovf)
        else $error("zero G divisor not flagged");

endmodule

FILE: src/sgfix_div.sv
module sgfix_div #(
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [DW-1:0]                   i_rem,
    input  logic [sgfix_pkg::SGF_QW-1:0]    i_low,
    input  logic [DW-1:0]                   i_den,
    input  logic [PW-1:0]                   i_side,
    output logic                            o_valid,
    output logic [sgfix_pkg::SGF_QW-1:0]    o_quo,
    output logic [PW-1:0]                   o_side
);
    import sgfix_pkg::*;

    localparam int AW = DW + SGF_QW;

    // per-stage sources and registers; remainder above, dividend/quotient bits below
    logic [AW-1:0] s_acc  [SGF_QW];
    logic [DW-1:0] s_den  [SGF_QW];
    logic [PW-1:0] s_side [SGF_QW];
    logic          s_vld  [SGF_QW];
    logic [AW-1:0] r_acc  [SGF_QW];
    logic [AW-1:0] n_acc  [SGF_QW];
    logic [DW-1:0] r_den  [SGF_QW];
    logic [PW-1:0] r_side [SGF_QW];
    logic          r_vld  [SGF_QW];

    assign s_acc[0]  = {i_rem, i_low};
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;
    assign s_vld[0]  = i_valid;

    // chain the stages
    for (genvar k = 1; k < SGF_QW; k++) begin : g_src
        assign s_acc[k]  = r_acc[k-1];
        assign s_den[k]  = r_den[k-1];
        assign s_side[k] = r_side[k-1];
        assign s_vld[k]  = r_vld[k-1];
    end

    // one restoring step per stage
    for (genvar k = 0; k < SGF_QW; k++) begin : g_step
        logic [DW:0] w_try;
        logic [DW:0] w_diff;
        logic        w_ge;

        assign w_try  = {s_acc[k][AW-1:SGF_QW], s_acc[k][SGF_QW-1]};
        assign w_diff = w_try - {1'b0, s_den[k]};
        assign w_ge   = w_try >= {1'b0, s_den[k]};
        assign n_acc[k] = {(w_ge ? w_diff[DW-1:0] : w_try[DW-1:0]),
                           s_acc[k][SGF_QW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k]  <= n_acc[k];
                r_den[k]  <= s_den[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_valid = r_vld[SGF_QW-1];
    assign o_quo   = r_acc[SGF_QW-1][SGF_QW-1:0];
    assign o_side  = r_side[SGF_QW-1];

endmodule

FILE: src/sgfix_obuf.sv
module sgfix_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sgfix_pkg::t_out     i_data,
    output logic                o_en,
    output logic                o_out_valid,
    output sgfix_pkg::t_out     o_out_data,
    input  logic                i_out_ready
);
    import sgfix_pkg::*;

    logic r_out_v;
    logic r_skid_v;
    logic n_out_v;
    logic n_skid_v;
    t_out r_out_d;
    t_out r_skid_d;
    t_out n_out_d;
    t_out n_skid_d;
    logic w_take;

    // pipe moves whenever the skid slot is free
    assign o_en   = !r_skid_v;
    assign w_take = r_out_v && i_out_ready;

    // output register plus one skid word
    always_comb begin
        n_out_v  = r_out_v;
        n_out_d  = r_out_d;
        n_skid_v = r_skid_v;
        n_skid_d = r_skid_d;
        if (r_skid_v) begin
            if (w_take) begin
                n_out_d  = r_skid_d;
                n_skid_v = 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            n_out_v = i_valid;
            n_out_d = i_data;
        end else if (i_valid) begin
            n_skid_v = 1'b1;
            n_skid_d = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_d  <= n_out_d;
        r_skid_d <= n_skid_d;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_d;

endmodule

FILE: tb/sgfix_checker.sv
module sgfix_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  sgfix_pkg::t_in                  i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  sgfix_pkg::t_out                 i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [sgfix_pkg::SGF_CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sgfix_pkg::*;

    localparam longint Q_ONE = 65536;
    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;

    longint min_rho, min_g, min_p;
    t_out   fixed_cells[$];

    function automatic longint clip32(input longint v);
        if (v > S_MAX) return S_MAX;
        if (v < S_MIN) return S_MIN;
        return v;
    endfunction

    // saturating q16 divide, zero divisor goes to the dividend's sign
    function automatic longint qdiv(input longint num, input longint den);
        if (den == 0) return (num > 0) ? S_MAX : ((num < 0) ? S_MIN : 0);
        return clip32((num * Q_ONE) / den);
    endfunction

    function automatic t_out fix_cell(input t_in c);
        longint r_old, g_old, p_old, e_old, mx, my, mz;
        longint r_new, g_new, p_new, ke, pres, d, q, p_out, e_new;
        longint unsigned sum, den, qm;
        t_out res;
        r_old = c.density;    g_old = c.gamma_term; p_old = c.pressure_term;
        e_old = c.energy;     mx = c.mom_x; my = c.mom_y; mz = c.mom_z;
        r_new = (r_old > min_rho) ? r_old : min_rho;
        g_new = (g_old > min_g) ? g_old : min_g;
        p_new = (p_old > min_p) ? p_old : min_p;
        // kinetic energy from the unsigned sum of squares
        sum = longint'(mx * mx) + longint'(my * my) + longint'(mz * mz);
        if (r_old == 0) begin
            ke = (sum != 0) ? S_MAX : 0;
        end else begin
            den = 2 * ((r_old < 0) ? -r_old : r_old);
            qm = sum / den;
            if (r_old > 0) ke = (qm > 64'd2147483647) ? S_MAX : longint'(qm);
            else ke = (qm > 64'd2147483648) ? S_MIN : -longint'(qm);
        end
        pres = qdiv(e_old - p_old - ke, g_old);
        d = Q_ONE + g_new;
        q = qdiv(p_new, d);
        p_out = p_new;
        if (-2 * pres > q) p_out = clip32(-4 * ((pres * d) / Q_ONE));
        e_new = clip32((pres * g_new) / Q_ONE + p_out + ke);
        res.new_density = r_new[31:0];
        res.new_energy = e_new[31:0];
        res.new_gamma_term = g_new[31:0];
        res.new_pressure_term = p_out[31:0];
        return res;
    endfunction

    assign o_pending = fixed_cells.size();

    // track registers, predict on input, compare on output
    always @(posedge i_clk) begin
        t_out exp_w;
        if (!i_rst_n) begin
            min_rho <= 0; min_g <= 0; min_p <= 0;
            o_fail_count <= 0;
            fixed_cells.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_DENSITY:  min_rho <= longint'($signed(i_cfg_data));
                    CFG_MIN_GAMMA:    min_g <= longint'($signed(i_cfg_data));
                    CFG_MIN_PRESSURE: min_p <= longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) fixed_cells.push_back(fix_cell(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (fixed_cells.size() == 0) begin
                    $error("output word with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = fixed_cells.pop_front();
                    if (exp_w != i_out_data) o_fail_count <= o_fail_count + 1;
                    if (exp_w.new_density != i_out_data.new_density)
                        $error("new_density exp %0d got %0d",
                               exp_w.new_density, i_out_data.new_density);
                    if (exp_w.new_energy != i_out_data.new_energy)
                        $error("new_energy exp %0d got %0d",
                               exp_w.new_energy, i_out_data.new_energy);
                    if (exp_w.new_gamma_term != i_out_data.new_gamma_term)
                        $error("new_gamma_term exp %0d got %0d",
                               exp_w.new_gamma_term, i_out_data.new_gamma_term);
                    if (exp_w.new_pressure_term != i_out_data.new_pressure_term)
                        $error("new_pressure_term exp %0d got %0d",
                               exp_w.new_pressure_term, i_out_data.new_pressure_term);
                end
            end
        end
    end
endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgfix_pkg::*;

    localparam int N_RANDOM = 1700;
    localparam int CYCLE_LIMIT = 400000;

    // index past the last register, writes to it are dropped
    localparam logic [SGF_CFG_IW-1:0] CFG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [SGF_CFG_IW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    t_in  in_data = '0;
    t_out out_data;
    int   fail_count, pending, cycles = 0;
    bit   quiet_tail = 0, hold_long = 0, sent_all = 0;

    stiffened_gas_state_fixup_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sgfix_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("stiffened_gas_state_fixup_core regression: fail");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_long = 0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    function automatic logic [31:0] field_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'h00010000;
            4: return 32'hffff0000;
            5: return $urandom_range(0, 32'h000fffff);
            6: return -$urandom_range(0, 32'h000fffff);
            7: return $urandom_range(0, 32'h00000fff);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in random_cell();
        t_in c;
        c.density = field_value();
        c.mom_x = field_value();
        c.mom_y = field_value();
        c.mom_z = field_value();
        c.energy = field_value();
        c.gamma_term = field_value();
        c.pressure_term = field_value();
        return c;
    endfunction

    task automatic send_cell(input t_in c);
        int n;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 10);
            repeat (n) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= c;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // valid stays up across consecutive writes, the caller drops it
    task automatic write_reg(input logic [SGF_CFG_IW-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // drain the pipe before touching the registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_mins(input logic [31:0] r, input logic [31:0] g, input logic [31:0] p);
        wait_idle();
        write_reg(CFG_MIN_DENSITY, r);
        write_reg(CFG_MIN_GAMMA, g);
        write_reg(CFG_MIN_PRESSURE, p);
        write_reg(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        t_in c;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cells with reset minimums: extremes, zero divisors, negative density
        c = '0;                                  send_cell(c);
        c = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff};  send_cell(c);
        c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000};  send_cell(c);
        c = '{32'h0, 32'h00010000, 32'h0, 32'h0, 32'h00050000, 32'h0, 32'h0};
        send_cell(c);
        c = '{32'hfffe0000, 32'h00020000, 32'h00030000, 32'h00040000,
              32'h00010000, 32'h00010000, 32'h00010000};  send_cell(c);
        c = '{32'h00010000, 32'h0, 32'h0, 32'h0, 32'hfff00000, 32'h00010000, 32'h0};
        send_cell(c);
        c = '{32'h00010000, 32'h0, 32'h0, 32'h0, 32'h00000000, 32'h0, 32'h00010000};
        send_cell(c);
        c = '{32'h00020000, 32'h00010000, 32'h0, 32'hffff0000,
              32'h00100000, 32'hffff0000, 32'h00020000};  send_cell(c);
        c = '{32'hffffffff, 32'h0, 32'h0, 32'h0, 32'hffffffff, 32'hffff0000, 32'hffffffff};
        send_cell(c);

        // one plus G zero via minimum, then largest and most negative minimums
        set_mins(32'h00010000, 32'hffff0000, 32'h00008000);
        c = '{32'h0, 32'h00010000, 32'h00010000, 32'h00010000,
              32'h00030000, 32'h80000000, 32'h00010000};  send_cell(c);
        c = '{32'h0, 32'h0, 32'h0, 32'h0, 32'hffff0000, 32'hffff0000, 32'hfff00000};
        send_cell(c);
        set_mins(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        repeat (4) send_cell(random_cell());
        set_mins(32'h80000000, 32'h80000000, 32'h80000000);
        repeat (4) send_cell(random_cell());

        // random phases across several register settings
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) set_mins(field_value(), field_value(), field_value());
            if (ph == 5) quiet_tail = 1;
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                if (ph == 2 && i == 20) hold_long = 1;
                send_cell(random_cell());
            end
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("stiffened_gas_state_fixup_core regression: pass");
        else
            $display("stiffened_gas_state_fixup_core regression: fail");
        $finish;
    end
endmodule
